### src/fpacos_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point arc cosine: shared package
// Number formats, polynomial constants, pipeline stage numbering and the
// per-stage record of the arc cosine pipeline.
// ----------------------------------------------------------------------------
package fpacos_pkg;

  // Number formats.
  localparam int IN_FRAC_BITS  = 15;
  localparam int OUT_FRAC_BITS = 14;
  localparam int POLY_FRAC     = 28;
  localparam int IN_W          = 17;
  localparam int OUT_W         = 16;

  // Magnitude |x| runs from 0 to exactly 1.0, so it needs one integer bit.
  localparam int MAG_W  = IN_FRAC_BITS + 1;
  // Q.28 values up to pi, which need two integer bits.
  localparam int POLY_W = POLY_FRAC + 2;

  // The square root operand is (1 - |x|) shifted up to 2*POLY_FRAC fraction bits.
  localparam int SQ_SH  = 2 * POLY_FRAC - IN_FRAC_BITS;
  localparam int NPAIR  = (MAG_W + SQ_SH + 1) / 2;
  localparam int NV_W   = 2 * NPAIR;
  localparam int ROOT_W = NPAIR;
  localparam int REM_W  = ROOT_W + 3;

  // Working value width: wide enough for every product that a stage keeps.
  localparam int PROD_W = POLY_W + ROOT_W;
  localparam int HMUL_W = POLY_W + MAG_W;
  localparam int CONV_W = POLY_W + OUT_FRAC_BITS + 1;
  localparam int HV_W   = (PROD_W > HMUL_W) ?
                          ((PROD_W > CONV_W) ? PROD_W : CONV_W) :
                          ((HMUL_W > CONV_W) ? HMUL_W : CONV_W);

  // Polynomial coefficients and pi, all Q.28.
  localparam logic [POLY_W-1:0] COEF_C3 = POLY_W'(5027608);
  localparam logic [POLY_W-1:0] COEF_C2 = POLY_W'(19934285);
  localparam logic [POLY_W-1:0] COEF_C1 = POLY_W'(56939026);
  localparam logic [POLY_W-1:0] COEF_C0 = POLY_W'(421639302);
  localparam logic [POLY_W-1:0] PI_Q28  = POLY_W'(843314857);

  localparam longint OUT_MAX = (longint'(1) << OUT_W) - 1;
  localparam longint ANG_PI  = ((longint'(843314857) << OUT_FRAC_BITS) +
                                (longint'(1) << (POLY_FRAC - 1))) >> POLY_FRAC;
  localparam longint ANG_LIM = (ANG_PI < OUT_MAX) ? ANG_PI : OUT_MAX;

  // Stage numbering. Stage 0 takes the request; stages 1..NPAIR each run one
  // square root digit (the first six also run the Horner steps).
  localparam int ST_RND = NPAIR + 1;
  localparam int ST_MUL = NPAIR + 2;
  localparam int ST_FIN = NPAIR + 3;
  localparam int ST_OUT = NPAIR + 4;

  // Horner step numbers within the square root stages.
  localparam int HS_MUL1 = 1;
  localparam int HS_ADD1 = 2;
  localparam int HS_MUL2 = 3;
  localparam int HS_ADD2 = 4;
  localparam int HS_MUL3 = 5;
  localparam int HS_ADD3 = 6;

  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  dif;
    logic [HV_W-1:0]   hv;
    logic [ROOT_W-1:0] q;
    logic [REM_W-1:0]  rem;
  } stage_t;

endpackage

### src/fpacos_in_if.sv
// ----------------------------------------------------------------------------
// Fixed-point arc cosine: request channel
// Valid/ready channel that carries one signed cosine value per request.
// ----------------------------------------------------------------------------
interface fpacos_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fpacos_pkg::IN_W-1:0]   cos_value;

  modport source (output valid, output cos_value, input ready);
  modport sink   (input valid, input cos_value, output ready);
endinterface

### src/fpacos_out_if.sv
// ----------------------------------------------------------------------------
// Fixed-point arc cosine: result channel
// Valid/ready channel that carries one unsigned angle per request.
// ----------------------------------------------------------------------------
interface fpacos_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [fpacos_pkg::OUT_W-1:0]         angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

### src/fixed_point_arccos_core.sv
// ----------------------------------------------------------------------------
// Fixed-point arc cosine core
// Pipelined acos(x) = p(|x|) * sqrt(1 - |x|), mirrored to pi - acos for
// negative x, with a cubic Horner polynomial and a digit-per-stage root.
// ----------------------------------------------------------------------------
//
//   channel   | direction | payload                  | handshake
//   ----------+-----------+--------------------------+--------------------
//   in_chan   | sink      | cos_value, s17, Q.15     | valid/ready
//   out_chan  | source    | angle, u16, Q.14, 0..pi  | valid/ready
//
// One request enters per clock cycle while out_chan does not stall; each result
// passes through every stage register in order, from stage 0 to ST_OUT.
// The depth is set by the square root, which resolves one root bit per stage
// over NPAIR stages; the Horner polynomial runs alongside in the first six.
// Reset clears only the stage valid bits; the data registers carry no reset.
// A stage holds when its successor is full and cannot move, so a stall on
// out_chan backs up stage by stage and bubbles still collapse; nothing is
// dropped or issued twice.
// ----------------------------------------------------------------------------
module fixed_point_arccos_core (
  input  logic                clk,
  input  logic                rst_n,
  fpacos_in_if.sink           in_chan,
  fpacos_out_if.source        out_chan
);

  logic [fpacos_pkg::ST_OUT:0] valid_r;
  logic [fpacos_pkg::ST_OUT:0] en;
  fpacos_pkg::stage_t          pipe_r   [0:fpacos_pkg::ST_OUT];
  fpacos_pkg::stage_t          pipe_nxt [0:fpacos_pkg::ST_OUT];

  // Rounds a product of a Q.28 value and the Q.15 magnitude back to Q.28,
  // half up on the magnitude.
  function automatic logic [fpacos_pkg::POLY_W-1:0] rnd_in(
    input logic [fpacos_pkg::HV_W-1:0] x
  );
    logic [fpacos_pkg::HV_W-1:0] t;
    t = x + (fpacos_pkg::HV_W'(1) << (fpacos_pkg::IN_FRAC_BITS - 1));
    return fpacos_pkg::POLY_W'(t >> fpacos_pkg::IN_FRAC_BITS);
  endfunction

  // --------------------------------------------------------------------------
  // Flow control: a stage may load when it is empty or its content moves on.
  // --------------------------------------------------------------------------
  assign en[fpacos_pkg::ST_OUT] = !valid_r[fpacos_pkg::ST_OUT] || out_chan.ready;

  for (genvar k = 0; k < fpacos_pkg::ST_OUT; k++) begin : g_en
    assign en[k] = !valid_r[k] || en[k+1];
  end

  assign in_chan.ready  = en[0];
  assign out_chan.valid = valid_r[fpacos_pkg::ST_OUT];
  assign out_chan.angle = pipe_r[fpacos_pkg::ST_OUT].hv[fpacos_pkg::OUT_W-1:0];

  // --------------------------------------------------------------------------
  // Stage 0: magnitude, saturated to 1.0, and 1 - |x| for the square root.
  // --------------------------------------------------------------------------
  logic [fpacos_pkg::IN_W-1:0] raw;
  logic [fpacos_pkg::IN_W-1:0] mag_full;
  logic [fpacos_pkg::IN_W-1:0] one_full;

  assign raw      = fpacos_pkg::IN_W'(in_chan.cos_value);
  assign one_full = fpacos_pkg::IN_W'(1) << fpacos_pkg::IN_FRAC_BITS;

  always_comb begin
    pipe_nxt[0]     = '0;
    pipe_nxt[0].neg = raw[fpacos_pkg::IN_W-1];
    mag_full        = raw[fpacos_pkg::IN_W-1] ? (fpacos_pkg::IN_W'(0) - raw) : raw;
    if (mag_full > one_full) begin
      mag_full = one_full;
    end
    pipe_nxt[0].mag = fpacos_pkg::MAG_W'(mag_full);
    pipe_nxt[0].dif = fpacos_pkg::MAG_W'(one_full - mag_full);
  end

  // --------------------------------------------------------------------------
  // Stages 1..NPAIR: one restoring square root digit each, plus the Horner
  // steps in the first six. All Horner terms stay positive: p1 > 0, p2 < 0
  // (its magnitude is kept) and p3 > 0 over the whole input range.
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= fpacos_pkg::NPAIR; k++) begin : g_sq
    logic [fpacos_pkg::NV_W-1:0]              nv;
    logic [fpacos_pkg::REM_W-1:0]             rsh;
    logic [fpacos_pkg::REM_W-1:0]             trial;
    logic [fpacos_pkg::HMUL_W-1:0]            pm;

    always_comb begin
      pipe_nxt[k] = pipe_r[k-1];

      nv    = fpacos_pkg::NV_W'(pipe_r[k-1].dif) << fpacos_pkg::SQ_SH;
      rsh   = {pipe_r[k-1].rem[fpacos_pkg::REM_W-3:0],
               nv[2*(fpacos_pkg::NPAIR-k)+1 -: 2]};
      trial = fpacos_pkg::REM_W'({pipe_r[k-1].q, 2'b01});
      if (rsh >= trial) begin
        pipe_nxt[k].rem = rsh - trial;
        pipe_nxt[k].q   = {pipe_r[k-1].q[fpacos_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        pipe_nxt[k].rem = rsh;
        pipe_nxt[k].q   = {pipe_r[k-1].q[fpacos_pkg::ROOT_W-2:0], 1'b0};
      end

      pm = '0;
      if (k == fpacos_pkg::HS_MUL1) begin
        pm = fpacos_pkg::HMUL_W'(fpacos_pkg::COEF_C3) *
             fpacos_pkg::HMUL_W'(pipe_r[k-1].mag);
        pipe_nxt[k].hv = fpacos_pkg::HV_W'(pm);
      end else if (k == fpacos_pkg::HS_MUL2 || k == fpacos_pkg::HS_MUL3) begin
        pm = fpacos_pkg::HMUL_W'(pipe_r[k-1].hv[fpacos_pkg::POLY_W-1:0]) *
             fpacos_pkg::HMUL_W'(pipe_r[k-1].mag);
        pipe_nxt[k].hv = fpacos_pkg::HV_W'(pm);
      end else if (k == fpacos_pkg::HS_ADD1) begin
        pipe_nxt[k].hv = fpacos_pkg::HV_W'(fpacos_pkg::COEF_C2 - rnd_in(pipe_r[k-1].hv));
      end else if (k == fpacos_pkg::HS_ADD2) begin
        pipe_nxt[k].hv = fpacos_pkg::HV_W'(fpacos_pkg::COEF_C1 - rnd_in(pipe_r[k-1].hv));
      end else if (k == fpacos_pkg::HS_ADD3) begin
        pipe_nxt[k].hv = fpacos_pkg::HV_W'(fpacos_pkg::COEF_C0 - rnd_in(pipe_r[k-1].hv));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Root rounding: round to nearest when the remainder exceeds the root.
  // --------------------------------------------------------------------------
  always_comb begin
    pipe_nxt[fpacos_pkg::ST_RND]   = pipe_r[fpacos_pkg::ST_RND-1];
    pipe_nxt[fpacos_pkg::ST_RND].q = pipe_r[fpacos_pkg::ST_RND-1].q +
      fpacos_pkg::ROOT_W'(pipe_r[fpacos_pkg::ST_RND-1].rem >
                          fpacos_pkg::REM_W'(pipe_r[fpacos_pkg::ST_RND-1].q));
  end

  // --------------------------------------------------------------------------
  // Polynomial times root.
  // --------------------------------------------------------------------------
  logic [fpacos_pkg::PROD_W-1:0] pr;

  always_comb begin
    pipe_nxt[fpacos_pkg::ST_MUL] = pipe_r[fpacos_pkg::ST_MUL-1];
    pr = fpacos_pkg::PROD_W'(pipe_r[fpacos_pkg::ST_MUL-1].hv[fpacos_pkg::POLY_W-1:0]) *
         fpacos_pkg::PROD_W'(pipe_r[fpacos_pkg::ST_MUL-1].q);
    pipe_nxt[fpacos_pkg::ST_MUL].hv = fpacos_pkg::HV_W'(pr);
  end

  // --------------------------------------------------------------------------
  // Back to Q.28, mirror for negative inputs and clamp to 0..pi.
  // --------------------------------------------------------------------------
  logic [fpacos_pkg::HV_W-1:0]   fin_t;
  logic [fpacos_pkg::POLY_W-1:0] fin_r;

  always_comb begin
    pipe_nxt[fpacos_pkg::ST_FIN] = pipe_r[fpacos_pkg::ST_FIN-1];
    fin_t = pipe_r[fpacos_pkg::ST_FIN-1].hv +
            (fpacos_pkg::HV_W'(1) << (fpacos_pkg::POLY_FRAC - 1));
    fin_r = fpacos_pkg::POLY_W'(fin_t >> fpacos_pkg::POLY_FRAC);
    if (pipe_r[fpacos_pkg::ST_FIN-1].neg) begin
      if (fin_r > fpacos_pkg::PI_Q28) begin
        fin_r = '0;
      end else begin
        fin_r = fpacos_pkg::PI_Q28 - fin_r;
      end
    end else if (fin_r > fpacos_pkg::PI_Q28) begin
      fin_r = fpacos_pkg::PI_Q28;
    end
    pipe_nxt[fpacos_pkg::ST_FIN].hv = fpacos_pkg::HV_W'(fin_r);
  end

  // --------------------------------------------------------------------------
  // Convert Q.28 to the output format, rounding half up, and saturate.
  // --------------------------------------------------------------------------
  logic [fpacos_pkg::HV_W-1:0] cv_t;
  logic [fpacos_pkg::HV_W-1:0] cv_a;

  always_comb begin
    pipe_nxt[fpacos_pkg::ST_OUT] = pipe_r[fpacos_pkg::ST_OUT-1];
    cv_t = (fpacos_pkg::HV_W'(pipe_r[fpacos_pkg::ST_OUT-1].hv[fpacos_pkg::POLY_W-1:0])
            << fpacos_pkg::OUT_FRAC_BITS) +
           (fpacos_pkg::HV_W'(1) << (fpacos_pkg::POLY_FRAC - 1));
    cv_a = cv_t >> fpacos_pkg::POLY_FRAC;
    if (cv_a > fpacos_pkg::HV_W'(fpacos_pkg::OUT_MAX)) begin
      cv_a = fpacos_pkg::HV_W'(fpacos_pkg::OUT_MAX);
    end
    pipe_nxt[fpacos_pkg::ST_OUT].hv = cv_a;
  end

  // --------------------------------------------------------------------------
  // Stage registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en[0]) begin
      valid_r[0] <= in_chan.valid;
    end
  end

  for (genvar k = 1; k <= fpacos_pkg::ST_OUT; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en[k]) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
  end

  for (genvar k = 0; k <= fpacos_pkg::ST_OUT; k++) begin : g_dat
    always_ff @(posedge clk) begin
      if (en[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0] |-> in_chan.ready)
    else $error("request refused while the first stage is empty");

  a_request_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> valid_r[0])
    else $error("accepted request did not reach the first stage");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[fpacos_pkg::NPAIR] |->
      pipe_r[fpacos_pkg::NPAIR].rem <=
      fpacos_pkg::REM_W'({pipe_r[fpacos_pkg::NPAIR].q, 1'b0}))
    else $error("square root remainder out of bounds");

  a_poly_pos: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[fpacos_pkg::NPAIR] |->
      pipe_r[fpacos_pkg::NPAIR].hv[fpacos_pkg::POLY_W-1:0] != '0)
    else $error("polynomial value not positive");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> longint'(out_chan.angle) <= fpacos_pkg::ANG_LIM)
    else $error("angle above pi");
`endif

endmodule

### sim/fpacos_checker.sv
// ----------------------------------------------------------------------------
// Fixed-point arc cosine: result checker
// Watches both channels of the arc cosine core. It predicts the angle for
// every accepted cosine value and compares it with the results in order.
// ----------------------------------------------------------------------------
module fpacos_checker (
  input  logic   clk,
  input  logic   rst_n,
  fpacos_in_if   in_mon,
  fpacos_out_if  out_mon,
  output int     fail_count,
  output int     pending,
  output int     checked
);

  // Q.28 polynomial coefficients and pi.
  localparam longint K_C3      = 64'sd5027608;
  localparam longint K_C2      = 64'sd19934285;
  localparam longint K_C1      = 64'sd56939026;
  localparam longint K_C0      = 64'sd421639302;
  localparam longint K_PI      = 64'sd843314857;
  localparam longint UNIT      = longint'(1) << fpacos_pkg::IN_FRAC_BITS;
  localparam longint HALF_IN   = longint'(1) << (fpacos_pkg::IN_FRAC_BITS - 1);
  localparam longint HALF_POLY = longint'(1) << (fpacos_pkg::POLY_FRAC - 1);
  localparam longint ANGLE_TOP = (longint'(1) << fpacos_pkg::OUT_W) - 1;

  typedef struct {
    logic [fpacos_pkg::IN_W-1:0]  cos_value;
    logic [fpacos_pkg::OUT_W-1:0] angle;
  } angle_due_t;

  angle_due_t angle_due_q[$];

  // One Horner product, scaled back to Q.28 with rounding half away from zero.
  function automatic longint horner_step(longint v, longint a);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m * a + HALF_IN) >> fpacos_pkg::IN_FRAC_BITS;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [fpacos_pkg::OUT_W-1:0] predict_angle(
    logic [fpacos_pkg::IN_W-1:0] raw
  );
    logic   neg;
    longint mag;
    longint p;
    longint n;
    longint root;
    longint trial;
    longint r;
    longint ang;
    neg = raw[fpacos_pkg::IN_W-1];
    mag = neg ? (longint'(1) << fpacos_pkg::IN_W) - longint'(raw) : longint'(raw);
    // Magnitudes above one saturate to exactly one.
    if (mag > UNIT) mag = UNIT;
    p = horner_step(-K_C3, mag) + K_C2;
    p = horner_step(p, mag) - K_C1;
    p = horner_step(p, mag) + K_C0;
    // Square root of (1 - |x|) in Q.28, rounded to nearest.
    n = (UNIT - mag) << fpacos_pkg::SQ_SH;
    root = 0;
    for (int i = 28; i >= 0; i--) begin
      trial = root | (longint'(1) << i);
      if (trial * trial <= n) root = trial;
    end
    if (n - root * root > root) root++;
    r = 0;
    if (p > 0) r = (p * root + HALF_POLY) >> fpacos_pkg::POLY_FRAC;
    if (neg) r = K_PI - r;
    if (r < 0) r = 0;
    if (r > K_PI) r = K_PI;
    ang = ((r << fpacos_pkg::OUT_FRAC_BITS) + HALF_POLY) >> fpacos_pkg::POLY_FRAC;
    if (ang > ANGLE_TOP) ang = ANGLE_TOP;
    return fpacos_pkg::OUT_W'(ang);
  endfunction

  always @(posedge clk) begin
    angle_due_t due;
    if (!rst_n) begin
      angle_due_q.delete();
      fail_count <= 0;
      pending    <= 0;
      checked    <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        due.cos_value = in_mon.cos_value;
        due.angle     = predict_angle(in_mon.cos_value);
        angle_due_q.push_back(due);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (angle_due_q.size() == 0) begin
          $error("angle %0d arrived with no request outstanding", out_mon.angle);
          fail_count <= fail_count + 1;
        end else begin
          due = angle_due_q.pop_front();
          checked <= checked + 1;
          if (out_mon.angle !== due.angle) begin
            $error("angle mismatch for cos_value %0d: expected %0d, actual %0d",
                   $signed(due.cos_value), due.angle, out_mon.angle);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= angle_due_q.size();
    end
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Fixed-point arc cosine: testbench top
// Drives cosine values into the arc cosine core in random bursts, stalls the
// angle output on a pattern of its own, and gives the verdict from the
// checker's failure count and its count of pending angles.
// ----------------------------------------------------------------------------
module tb_top;

  // Total number of requests, directed ones included.
  localparam int TOTAL_ITEMS = 1650;
  // Length of the one long output hold-off that fills the pipeline.
  localparam int HOLD_CYCLES = 400;
  // The pipeline is 34 stages deep; this covers it with some margin.
  localparam int DRAIN_CYCLES = 60;
  // Cycles without any handshake before the run is declared hung. The long
  // hold-off is the longest quiet stretch of a correct run.
  localparam int IDLE_LIMIT = 3000;
  // Requests sent before the receiver starts its long hold-off.
  localparam int HOLD_AFTER = 300;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_CHOKED
  } rx_mode_t;

  logic clk;
  logic rst_n;

  int fail_count;
  int pending;
  int checked;

  int sent;
  int beyond_unit;
  int idle_cycles;
  bit hold_done;

  fpacos_in_if  in_chan ();
  fpacos_out_if out_chan ();

  fixed_point_arccos_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fpacos_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one cosine value and returns at the edge where the core takes it.
  // Valid stays high on return, so back-to-back calls form a burst.
  task automatic push_cos(input logic signed [fpacos_pkg::IN_W-1:0] x);
    in_chan.valid     <= 1'b1;
    in_chan.cos_value <= x;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
    if (x > 17'sd32768 || x < -17'sd32768) beyond_unit++;
  endtask

  // Request side: reset, a directed list, then random bursts with gaps.
  initial begin : stimulus
    // Extremes of the field, exact and nearly exact +/-1.0, the saturated
    // magnitudes just above one and at the ends of the 17-bit range, and a
    // few points in between.
    int directed[] = '{0, 1, -1, 100, -100, 16384, -16384, 23170, -23170,
                       32700, -32700, 32767, -32767, 32768, -32768,
                       32769, -32769, 40000, -40000, 65535, -65536};
    int burst;
    int gap;
    int pick;
    int mag;
    logic signed [fpacos_pkg::IN_W-1:0] x;

    sent        = 0;
    beyond_unit = 0;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.cos_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed values go in back to back.
    foreach (directed[i]) push_cos(fpacos_pkg::IN_W'(directed[i]));

    while (sent < TOTAL_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < TOTAL_ITEMS; k++) begin
        // Most values lie in the legal range; a share sits close to +/-1.0
        // where the root is small, some near zero, and the rest use all
        // 17 bits so that every bit toggles and magnitudes saturate.
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          x = fpacos_pkg::IN_W'(int'($urandom_range(0, 65536)) - 32768);
        end else if (pick < 75) begin
          mag = 32768 - int'($urandom_range(0, 300));
          x = $urandom_range(0, 1) ? fpacos_pkg::IN_W'(-mag) : fpacos_pkg::IN_W'(mag);
        end else if (pick < 85) begin
          x = fpacos_pkg::IN_W'(int'($urandom_range(0, 512)) - 256);
        end else begin
          x = fpacos_pkg::IN_W'($urandom);
        end
        push_cos(x);
      end
      // A gap of zero lets the next burst follow without a bubble.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) begin
          in_chan.cos_value <= fpacos_pkg::IN_W'($urandom);
          @(posedge clk);
        end
      end
    end
    in_chan.valid <= 1'b0;

    // Wait for every outstanding angle, then watch a little longer for
    // anything the core should not produce.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d cosine values (%0d directed, %0d beyond +/-1.0); checked %0d angles.",
             sent, directed.size(), beyond_unit, checked);
    $display("The output was held off for %0d cycles while requests kept coming.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: ready follows a changing mode, from fully open to mostly
  // stalled. Once, after some traffic, it drops for a long stretch so that
  // the pipeline fills and in_chan.ready must fall.
  initial begin : receiver
    rx_mode_t mode;
    int       span;

    hold_done = 1'b0;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!hold_done && sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 150);
      for (int c = 0; c < span; c++) begin
        case (mode)
          RX_OPEN: begin
            out_chan.ready <= 1'b1;
          end
          RX_RANDOM: begin
            out_chan.ready <= ($urandom_range(0, 3) != 0);
          end
          RX_PERIODIC: begin
            out_chan.ready <= ((c % 5) != 4);
          end
          default: begin
            out_chan.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // A hung core shows up as a long run of cycles in which neither channel
  // completes a request.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles.", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
